// ===== rtl/dptt_pkg.sv =====
`default_nettype none
package dptt_pkg;

  // field widths
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 16;
  localparam int BOUND_W = 2;
  localparam int MOVE_W  = 32;
  localparam int OP_W    = 2;

  // slot remainder unit: key bits consumed per cycle
  localparam int MOD_DIGIT = 4;
  localparam int MOD_STEPS = KEY_W / MOD_DIGIT;

  // command codes
  localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic [KEY_W-1:0]          position_key;
    logic [DEPTH_W-1:0]        search_depth;
    logic signed [SCORE_W-1:0] entry_score;
    logic [BOUND_W-1:0]        entry_bound;
    logic                      entry_null;
    logic [MOVE_W-1:0]         entry_move;
  } in_beat_t;

  typedef struct packed {
    logic                      key_match;
    logic [BOUND_W-1:0]        found_bound;
    logic signed [SCORE_W-1:0] found_score;
    logic                      found_null;
    logic [MOVE_W-1:0]         found_move;
  } out_beat_t;

  // part of a slot that a clear wipes
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic [SCORE_W-1:0] score;
    logic [BOUND_W-1:0] bound;
  } slot_a_t;

  // part of a slot that survives a clear command; the clear after reset wipes it too
  typedef struct packed {
    logic              nul_flag;
    logic [MOVE_W-1:0] move;
  } slot_b_t;

  typedef struct packed {
    logic ld_item;
    logic mod_start;
    logic rd_en;
    logic store_commit;
    logic out_load;
    logic clr_go;
    logic clr_b;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/dptt_slot_mod.sv =====
`default_nettype none
// key modulo ENTRIES, MOD_DIGIT bits per cycle, MSB first; for a power of two the slot is the low IW key bits
module dptt_slot_mod #(
  parameter int ENTRIES = 65536,
  parameter int IW      = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [dptt_pkg::KEY_W-1:0] key,
  output logic                            done,
  output logic [IW-1:0]                   slot
);

  localparam bit        IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
  localparam logic [IW:0] MODV  = (IW+1)'(ENTRIES);
  localparam int        CW      = (dptt_pkg::MOD_STEPS > 1) ? $clog2(dptt_pkg::MOD_STEPS) : 1;

  logic [IW-1:0]                rem_r, rem_nxt;
  logic [dptt_pkg::KEY_W-1:0]   sh_r;
  logic [CW-1:0]                cnt_r;
  logic                         done_r;

  // one digit of restoring reduction
  always_comb begin
    logic [IW:0] t;
    rem_nxt = rem_r;
    for (int i = 0; i < dptt_pkg::MOD_DIGIT; i++) begin
      t = {rem_nxt, sh_r[dptt_pkg::KEY_W-1-i]};
      if (t >= MODV) begin
        t = t - MODV;
      end
      rem_nxt = t[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      cnt_r  <= '0;
      done_r <= IS_POW2;
    end else if (!done_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(dptt_pkg::MOD_STEPS - 1)) begin
        done_r <= 1'b1;
      end
    end
  end

  // datapath of the unit
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= IS_POW2 ? key[IW-1:0] : '0;
      sh_r  <= key;
    end else if (!done_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_r << dptt_pkg::MOD_DIGIT;
    end
  end

  assign done = done_r;
  assign slot = rem_r;

endmodule
`default_nettype wire

// ===== rtl/dptt_table_mem.sv =====
`default_nettype none
// slot storage, split in the cleared half and the kept half
module dptt_table_mem #(
  parameter int ENTRIES = 65536,
  parameter int IW      = 16
) (
  input  wire logic              clk,
  input  wire logic              wa_en,
  input  wire logic              wb_en,
  input  wire logic [IW-1:0]     waddr,
  input  wire dptt_pkg::slot_a_t wdata_a,
  input  wire dptt_pkg::slot_b_t wdata_b,
  input  wire logic              rd_en,
  input  wire logic [IW-1:0]     raddr,
  output dptt_pkg::slot_a_t      rdata_a,
  output dptt_pkg::slot_b_t      rdata_b
);

  dptt_pkg::slot_a_t mem_a [ENTRIES];
  dptt_pkg::slot_b_t mem_b [ENTRIES];
  dptt_pkg::slot_a_t rda_r;
  dptt_pkg::slot_b_t rdb_r;

  always_ff @(posedge clk) begin
    if (wa_en) begin
      mem_a[waddr] <= wdata_a;
    end
    if (wb_en) begin
      mem_b[waddr] <= wdata_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rda_r <= mem_a[raddr];
      rdb_r <= mem_b[raddr];
    end
  end

  assign rdata_a = rda_r;
  assign rdata_b = rdb_r;

endmodule
`default_nettype wire

// ===== rtl/dptt_datapath.sv =====
`default_nettype none
module dptt_datapath #(
  parameter int ENTRIES = 65536,
  parameter int IW      = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dptt_pkg::in_beat_t in_data,
  input  wire logic               out_stall,
  input  wire dptt_pkg::dp_cmd_t  cmd,
  output dptt_pkg::dp_sts_t       sts,
  output logic                    out_valid,
  output dptt_pkg::out_beat_t     out_data
);

  dptt_pkg::in_beat_t  item_r;
  dptt_pkg::out_beat_t out_r, out_nxt;
  logic                out_valid_r;
  logic [IW-1:0]       clr_cnt_r;
  logic                clr_last;
  logic [IW-1:0]       slot;
  logic                mod_done;
  logic                deeper;
  logic                match;
  logic                deep_enough;
  logic                wa_en, wb_en;
  logic [IW-1:0]       waddr;
  dptt_pkg::slot_a_t   wdata_a, rdata_a;
  dptt_pkg::slot_b_t   wdata_b, rdata_b;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_r <= in_data;
    end
  end

  dptt_slot_mod #(.ENTRIES(ENTRIES), .IW(IW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .key   (in_data.position_key),
    .done  (mod_done),
    .slot  (slot)
  );

  // clear sweep address
  assign clr_last = (clr_cnt_r == IW'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_go) begin
      clr_cnt_r <= clr_last ? '0 : clr_cnt_r + IW'(1);
    end
  end

  // depth-preferred replacement
  assign deeper = (item_r.search_depth >= rdata_a.depth);

  always_comb begin
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    waddr   = slot;
    wdata_a = '0;
    wdata_b = '0;
    if (cmd.clr_go) begin
      wa_en = 1'b1;
      wb_en = cmd.clr_b;
      waddr = clr_cnt_r;
    end else if (cmd.store_commit && deeper) begin
      wa_en           = 1'b1;
      wb_en           = 1'b1;
      wdata_a.key     = item_r.position_key;
      wdata_a.depth   = item_r.search_depth;
      wdata_a.score   = item_r.entry_score;
      wdata_a.bound   = item_r.entry_bound;
      wdata_b.nul_flag = item_r.entry_null;
      wdata_b.move    = item_r.entry_move;
    end
  end

  dptt_table_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
    .clk     (clk),
    .wa_en   (wa_en),
    .wb_en   (wb_en),
    .waddr   (waddr),
    .wdata_a (wdata_a),
    .wdata_b (wdata_b),
    .rd_en   (cmd.rd_en),
    .raddr   (slot),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // probe result
  assign match       = (rdata_a.key == item_r.position_key);
  assign deep_enough = match && (rdata_a.depth >= item_r.search_depth);

  always_comb begin
    out_nxt.key_match   = match;
    out_nxt.found_bound = deep_enough ? rdata_a.bound : '0;
    out_nxt.found_score = match ? rdata_a.score : '0;
    out_nxt.found_null  = deep_enough ? rdata_b.nul_flag : 1'b0;
    out_nxt.found_move  = match ? rdata_b.move : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign sts.mod_done = mod_done;
  assign sts.clr_last = clr_last;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule
`default_nettype wire

// ===== rtl/dptt_ctrl.sv =====
`default_nettype none
module dptt_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [dptt_pkg::OP_W-1:0] in_op,
  input  wire dptt_pkg::dp_sts_t         sts,
  output dptt_pkg::dp_cmd_t              cmd,
  output logic                           in_stall
);

  localparam logic [2:0] S_RCLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  logic [2:0]                  st_r, st_nxt;
  logic [dptt_pkg::OP_W-1:0]   op_r, op_nxt;

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    cmd    = '0;
    case (st_r)
      // wipe both halves after reset
      S_RCLR: begin
        cmd.clr_go = 1'b1;
        cmd.clr_b  = 1'b1;
        if (sts.clr_last) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          if (in_op == dptt_pkg::OP_PROBE || in_op == dptt_pkg::OP_STORE) begin
            cmd.ld_item   = 1'b1;
            cmd.mod_start = 1'b1;
            st_nxt        = S_MOD;
          end else if (in_op == dptt_pkg::OP_CLEAR) begin
            st_nxt = S_CLR;
          end
        end
      end
      // wait for the slot, then read it
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.rd_en = 1'b1;
          st_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_r == dptt_pkg::OP_STORE) begin
          cmd.store_commit = 1'b1;
          st_nxt           = S_IDLE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      // clear keeps null flag and move
      S_CLR: begin
        cmd.clr_go = 1'b1;
        if (sts.clr_last) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RCLR;
      op_r <= dptt_pkg::OP_PROBE;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
    end
  end

  assign in_stall = (st_r != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/depth_preferred_transposition_table_unit.sv =====
// channel | dir | handshake          | beat
// in_     | in  | in_valid/in_stall   | dptt_pkg::in_beat_t (probe, store, clear)
// out_    | out | out_valid/out_stall | dptt_pkg::out_beat_t (one per probe)
//
// Probe and store pass the idle, slot remainder and evaluate states; the remainder
// unit consumes 4 key bits a cycle (16 steps) unless TABLE_ENTRIES is a power of
// two, when the slot is the low key bits. A clear writes one entry per cycle.
// After reset a clearing pass over the whole table runs with in_stall high.
// A probe result waits in the output register; a stalled output holds the
// probe in its evaluate state until the register frees.
`default_nettype none
module depth_preferred_transposition_table_unit #(
  parameter int TABLE_ENTRIES = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dptt_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dptt_pkg::out_beat_t      out_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  dptt_pkg::dp_cmd_t cmd;
  dptt_pkg::dp_sts_t sts;

  dptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.opcode),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dptt_datapath #(.ENTRIES(TABLE_ENTRIES), .IW(IW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // an accepted probe keeps the input side busy next cycle
  a_probe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == dptt_pkg::OP_PROBE) |=> in_stall)
    else $error("probe accepted but input not stalled");

  // a result is never loaded over one still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  // table writes for a store only while the item is in flight
  a_store_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_commit |-> (in_stall && !cmd.clr_go))
    else $error("store commit outside item processing");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 65536;
  localparam int RANDOM_ITEMS  = 1700;
  // a clear walks the whole table with in_stall high, so allow several of those
  localparam int QUIET_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 50;
  localparam int REPORT_MAX    = 10;
  // command code the block has no use for
  localparam logic [dptt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Mirror of the table: tracks every slot and the probe results still owed.
  class tt_scoreboard;
    int unsigned slots;
    bit [dptt_pkg::KEY_W-1:0]   slot_tag [];
    bit [dptt_pkg::DEPTH_W-1:0] slot_depth_q [];
    bit [dptt_pkg::SCORE_W-1:0] slot_score_q [];
    bit [dptt_pkg::BOUND_W-1:0] slot_bound_q [];
    bit                         slot_null_q [];
    bit [dptt_pkg::MOVE_W-1:0]  slot_move_q [];
    dptt_pkg::out_beat_t        owed_probes [$];
    int unsigned                mismatches;
    int unsigned                probes_seen;

    function new(int unsigned n);
      slots = n;
      slot_tag = new[n];
      slot_depth_q = new[n];
      slot_score_q = new[n];
      slot_bound_q = new[n];
      slot_null_q = new[n];
      slot_move_q = new[n];
      mismatches = 0;
      probes_seen = 0;
    endfunction

    // apply one accepted command; a probe queues the result it must produce
    function void apply_command(dptt_pkg::in_beat_t b);
      int unsigned idx;
      dptt_pkg::out_beat_t r;
      idx = int'(b.position_key % 64'(slots));
      case (b.opcode)
        dptt_pkg::OP_PROBE: begin
          r = '0;
          if (slot_tag[idx] == b.position_key) begin
            r.key_match = 1'b1;
            r.found_score = slot_score_q[idx];
            r.found_move = slot_move_q[idx];
            // bound and null flag only when the stored search was deep enough
            if (slot_depth_q[idx] >= b.search_depth) begin
              r.found_bound = slot_bound_q[idx];
              r.found_null = slot_null_q[idx];
            end
          end
          owed_probes.push_back(r);
        end
        dptt_pkg::OP_STORE: begin
          // depth-preferred: equal or deeper replaces the slot
          if (b.search_depth >= slot_depth_q[idx]) begin
            slot_tag[idx] = b.position_key;
            slot_depth_q[idx] = b.search_depth;
            slot_score_q[idx] = b.entry_score;
            slot_bound_q[idx] = b.entry_bound;
            slot_null_q[idx] = b.entry_null;
            slot_move_q[idx] = b.entry_move;
          end
        end
        dptt_pkg::OP_CLEAR: begin
          // null flag and move survive a clear
          foreach (slot_tag[i]) begin
            slot_tag[i] = '0;
            slot_depth_q[i] = '0;
            slot_score_q[i] = '0;
            slot_bound_q[i] = '0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void report(string what, dptt_pkg::out_beat_t want,
                         dptt_pkg::out_beat_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t probe %0d %s: exp match=%0b bound=%0d score=%0d null=%0b move=%h",
                 $time, probes_seen, what, want.key_match, want.found_bound,
                 want.found_score, want.found_null, want.found_move);
        $display("    got match=%0b bound=%0d score=%0d null=%0b move=%h",
                 got.key_match, got.found_bound, got.found_score, got.found_null,
                 got.found_move);
      end
    endfunction

    function void check_probe_result(dptt_pkg::out_beat_t got);
      dptt_pkg::out_beat_t want;
      probes_seen++;
      if (owed_probes.size() == 0) begin
        report("unexpected beat", '0, got);
      end else begin
        want = owed_probes.pop_front();
        if (got.key_match !== want.key_match || got.found_bound !== want.found_bound ||
            got.found_score !== want.found_score || got.found_null !== want.found_null ||
            got.found_move !== want.found_move) begin
          report("field mismatch", want, got);
        end
      end
    endfunction

    function int unsigned owed();
      return owed_probes.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dptt_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dptt_pkg::out_beat_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [dptt_pkg::KEY_W-1:0] key_pool [$];

  tt_scoreboard sb = new(TABLE_ENTRIES);

  depth_preferred_transposition_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // beat monitors on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) sb.apply_command(in_data);
      if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_probe_result(out_data);
    end
  end

  // watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[depth_preferred_transposition_table_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic dptt_pkg::in_beat_t make_beat(
      logic [dptt_pkg::OP_W-1:0] op, logic [dptt_pkg::KEY_W-1:0] key,
      int unsigned depth, logic [dptt_pkg::SCORE_W-1:0] score,
      int unsigned bound, logic nul, logic [dptt_pkg::MOVE_W-1:0] mv);
    dptt_pkg::in_beat_t b;
    b.opcode = op;
    b.position_key = key;
    b.search_depth = dptt_pkg::DEPTH_W'(depth);
    b.entry_score = score;
    b.entry_bound = dptt_pkg::BOUND_W'(bound);
    b.entry_null = nul;
    b.entry_move = mv;
    return b;
  endfunction

  // mostly probes and stores on a small set of colliding keys
  function automatic dptt_pkg::in_beat_t random_beat();
    dptt_pkg::in_beat_t b;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) b.opcode = OP_UNUSED;
    else if (pick < 53) b.opcode = dptt_pkg::OP_PROBE;
    else b.opcode = dptt_pkg::OP_STORE;
    if ($urandom_range(99) < 85)
      b.position_key = key_pool[$urandom_range(key_pool.size() - 1)];
    else
      b.position_key = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 10) b.search_depth = '0;
    else if (pick < 20) b.search_depth = '1;
    else b.search_depth = dptt_pkg::DEPTH_W'($urandom_range(127));
    b.entry_score = dptt_pkg::SCORE_W'($urandom_range(65535));
    b.entry_bound = dptt_pkg::BOUND_W'($urandom_range(3));
    b.entry_null = 1'($urandom_range(1));
    b.entry_move = $urandom;
    return b;
  endfunction

  task automatic set_idling(int unsigned phase);
    case (phase)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 61;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 61;
      end
      default: begin
        send_idle_pct = 27;
        recv_stall_pct = 27;
      end
    endcase
  endtask

  // present one beat, with random idle cycles ahead of it, and hold until taken
  task automatic send_beat(dptt_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  initial begin
    logic [dptt_pkg::KEY_W-1:0] k1;
    logic [dptt_pkg::KEY_W-1:0] k2;
    logic [dptt_pkg::KEY_W-1:0] k3;
    logic [15:0] slot_base;
    dptt_pkg::in_beat_t b;
    int unsigned n;

    // key pool: groups of keys sharing one slot, plus the corner keys
    for (int g = 0; g < 12; g++) begin
      slot_base = 16'($urandom_range(65535));
      for (int k = 0; k < 4; k++)
        key_pool.push_back({$urandom, 16'($urandom_range(65535)), slot_base});
    end
    key_pool.push_back('0);
    key_pool.push_back('1);
    key_pool.push_back({$urandom, 16'($urandom_range(65535)), 16'h0000});
    key_pool.push_back({$urandom, 16'($urandom_range(65535)), 16'hFFFF});

    k1 = 64'h0123_4567_89AB_1234;
    k2 = 64'hFEDC_BA98_7654_1234;
    k3 = 64'h8000_0000_0000_5555;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: hits, misses, shallow hits, replacement and clear corners
    set_idling(3);
    send_beat(make_beat(dptt_pkg::OP_PROBE, '0, 0, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_PROBE, '1, 127, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_STORE, k1, 10, 16'h8000, 3, 1'b1, 32'hFFFF_FFFF));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k1, 10, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k1, 11, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_STORE, k1, 9, 16'h0001, 1, 1'b0, 32'h1));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k1, 0, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_STORE, k2, 10, 16'h7FFF, 1, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k1, 0, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k2, 127, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_STORE, k3, 127, 16'hFFFF, 0, 1'b1, 32'hA5A5_A5A5));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k3, 127, '0, 0, 1'b0, '0));
    send_beat(make_beat(OP_UNUSED, k3, 0, 16'h1234, 3, 1'b0, 32'h1));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k3, 0, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_STORE, '1, 127, '0, 2, 1'b1, 32'h5A5A_5A5A));
    send_beat(make_beat(dptt_pkg::OP_PROBE, '1, 127, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_STORE, '0, 5, 16'd100, 2, 1'b1, 32'h1234_5678));
    send_beat(make_beat(dptt_pkg::OP_PROBE, '0, 5, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_CLEAR, k1, 0, '0, 0, 1'b0, '0));
    // cleared slot 0 still matches key zero and keeps its move and null flag
    send_beat(make_beat(dptt_pkg::OP_PROBE, '0, 0, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k3, 0, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_PROBE, '1, 0, '0, 0, 1'b0, '0));
    send_beat(make_beat(dptt_pkg::OP_STORE, k2, 0, 16'hC000, 3, 1'b1, 32'h8000_0001));
    send_beat(make_beat(dptt_pkg::OP_PROBE, k2, 0, '0, 0, 1'b0, '0));

    // random part, two clears spread through it
    n = 0;
    while (n < RANDOM_ITEMS) begin
      set_idling(n * 4 / RANDOM_ITEMS);
      b = random_beat();
      if ((n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) && b.opcode != OP_UNUSED)
        b.opcode = dptt_pkg::OP_CLEAR;
      send_beat(b);
      if (b.opcode != OP_UNUSED) n++;
    end
    in_valid <= 1'b0;

    // drain outstanding probe results, then let a trailing store settle
    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("[depth_preferred_transposition_table_unit] OK");
    end else begin
      $display("[depth_preferred_transposition_table_unit] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
